/* hw/rtl/kmce_pkg.sv */
// kmce_pkg: shared types, constants and helpers for the key matrix change-event core
// no dependencies
package kmce_pkg;

  localparam int SWITCH_W = 8;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 4;
  localparam int STATE_W  = 2;
  localparam int TOTAL_W  = 7;
  localparam int CNT_W    = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // one half-row handed from the state update to the event scanner
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col_base;
    logic [SWITCH_W-1:0] prev;
    logic [SWITCH_W-1:0] cur;
    logic [TOTAL_W-1:0]  total;
  } kmce_job_t;

  function automatic logic [CNT_W-1:0] popcount8(input logic [SWITCH_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SWITCH_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/kmce_if.sv */
// kmce_in_if / kmce_out_if: valid/ready channels for half-row reports and key events
// depends on kmce_pkg for field widths
interface kmce_in_if import kmce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hand_side;
  logic [ROW_W-1:0]    scan_row;
  logic [SWITCH_W-1:0] switch_bits;
  logic                fresh_data;

  modport source (output valid, hand_side, scan_row, switch_bits, fresh_data, input ready);
  modport sink   (input valid, hand_side, scan_row, switch_bits, fresh_data, output ready);
endinterface

interface kmce_out_if import kmce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    event_row;
  logic [COL_W-1:0]    event_column;
  logic [STATE_W-1:0]  key_state;
  logic [TOTAL_W-1:0]  keys_down_total;
  logic                last_event;

  modport source (output valid, event_row, event_column, key_state, keys_down_total,
                  last_event, input ready);
  modport sink   (input valid, event_row, event_column, key_state, keys_down_total,
                  last_event, output ready);
endinterface

/* hw/rtl/key_matrix_change_events_core.sv */
// key_matrix_change_events_core: half-row reports in, per-key change events out
// the first event of a report is held in the job register, then driven from the output registers
// throughput: one event per cycle while the sink is ready; a report holds the column
//   scanner until its last event is loaded into the output register, one with no events
//   takes only its transfer, and a new report is taken in the cycle that last load happens
// state updates at the input transfer; synchronous active-low reset clears all key bits
// depends on kmce_pkg, kmce_if, kmce_state, kmce_emit
module key_matrix_change_events_core import kmce_pkg::*; #(
  parameter int ROW_COUNT         = 4,
  parameter int KEYS_PER_HALF_ROW = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  kmce_in_if.sink   in_if,
  kmce_out_if.source out_if
);

  logic      in_fire;
  logic      job_valid;
  logic      job_ready;
  kmce_job_t job;

  assign in_if.ready = job_ready;
  assign in_fire     = in_if.valid && job_ready;

  kmce_state #(
    .ROW_COUNT         (ROW_COUNT),
    .KEYS_PER_HALF_ROW (KEYS_PER_HALF_ROW)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .hand_side   (in_if.hand_side),
    .scan_row    (in_if.scan_row),
    .switch_bits (in_if.switch_bits),
    .fresh_data  (in_if.fresh_data),
    .job_valid   (job_valid),
    .job         (job)
  );

  kmce_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .out_if    (out_if)
  );

endmodule

/* hw/rtl/kmce_state.sv */
// kmce_state: per half-row current bits, previous bits at each report, keys-down count
// depends on kmce_pkg
module kmce_state import kmce_pkg::*; #(
  parameter int ROW_COUNT         = 4,
  parameter int KEYS_PER_HALF_ROW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                hand_side,
  input  logic [ROW_W-1:0]    scan_row,
  input  logic [SWITCH_W-1:0] switch_bits,
  input  logic                fresh_data,
  output logic                job_valid,
  output kmce_job_t           job
);

  localparam int HALF_ROWS = 2 * ROW_COUNT;
  localparam int IDX_W     = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int BITS_USED = (KEYS_PER_HALF_ROW < SWITCH_W) ? KEYS_PER_HALF_ROW : SWITCH_W;
  localparam logic [SWITCH_W-1:0] BIT_MASK = SWITCH_W'((1 << BITS_USED) - 1);
  localparam logic [COL_W-1:0] LEFT_BASE  = COL_W'(KEYS_PER_HALF_ROW - 1);
  localparam logic [COL_W-1:0] RIGHT_BASE = COL_W'(2 * KEYS_PER_HALF_ROW - 1);
  // enough for every switch of every half-row being down, and never below the event field
  localparam int SUM_RAW_W = $clog2(HALF_ROWS * SWITCH_W + 1);
  localparam int SUM_W     = (SUM_RAW_W > TOTAL_W) ? SUM_RAW_W : TOTAL_W;

  logic [SWITCH_W-1:0] cur_r  [HALF_ROWS];
  logic [SUM_W-1:0]    total_r, total_nxt;

  logic [5:0]          idx_wide;
  logic [IDX_W-1:0]    idx;
  logic                in_range;
  logic [SWITCH_W-1:0] old_cur, new_cur;
  logic                upd;

  assign in_range = 5'(scan_row) < 5'(ROW_COUNT);
  assign idx_wide = (hand_side ? 6'(ROW_COUNT) : 6'd0) + 6'(scan_row);
  assign idx      = idx_wide[IDX_W-1:0];
  assign upd      = fire && in_range;

  // the bits held before this report are the previous bits of the half-row
  assign old_cur   = cur_r[idx];
  assign new_cur   = fresh_data ? (switch_bits & BIT_MASK) : old_cur;
  assign total_nxt = total_r - SUM_W'(popcount8(old_cur)) + SUM_W'(popcount8(new_cur));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HALF_ROWS; i++) begin
        cur_r[i] <= '0;
      end
      total_r <= '0;
    end else if (upd) begin
      cur_r[idx] <= new_cur;
      total_r    <= total_nxt;
    end
  end

  // an idle half-row with nothing down gives no events
  assign job_valid = upd && ((old_cur | new_cur) != '0);

  always_comb begin
    job.row      = scan_row;
    job.col_base = hand_side ? RIGHT_BASE : LEFT_BASE;
    job.prev     = old_cur;
    job.cur      = new_cur;
    job.total    = (total_nxt > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : total_nxt[TOTAL_W-1:0];
  end

endmodule

/* hw/rtl/kmce_emit.sv */
// kmce_emit: walks set columns of one half-row, one event per cycle unless stalled
// depends on kmce_pkg and kmce_out_if
module kmce_emit import kmce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_load,
  input  kmce_job_t  job,
  output logic       job_ready,
  kmce_out_if.source out_if
);

  kmce_job_t           job_r;
  logic [SWITCH_W-1:0] pend_r;
  logic                busy_r;

  logic                out_valid_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [STATE_W-1:0]  state_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                last_r;

  logic [SWITCH_W-1:0] low_bit;
  logic [COL_W-1:0]    low_idx;
  logic                is_last;
  logic                out_load;

  // lowest pending bit first, which is the highest pending column number
  assign low_bit = pend_r & (~pend_r + SWITCH_W'(1));
  assign is_last = (pend_r & ~low_bit) == '0;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < SWITCH_W; i++) begin
      if (low_bit[i]) low_idx = COL_W'(i);
    end
  end

  assign out_load  = busy_r && (!out_valid_r || out_if.ready);
  assign job_ready = !busy_r || (out_load && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new job only loads when the previous one is done or finishing
      if (job_load) begin
        busy_r <= 1'b1;
        job_r  <= job;
        pend_r <= job.prev | job.cur;
      end else if (out_load) begin
        pend_r <= pend_r & ~low_bit;
        if (is_last) busy_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        row_r       <= job_r.row;
        col_r       <= job_r.col_base - low_idx;
        state_r     <= {|(job_r.cur & low_bit), |(job_r.prev & low_bit)};
        total_r     <= job_r.total;
        last_r      <= is_last;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.event_row       = row_r;
  assign out_if.event_column    = col_r;
  assign out_if.key_state       = state_r;
  assign out_if.keys_down_total = total_r;
  assign out_if.last_event      = last_r;

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking bench for key_matrix_change_events_core
// drives half-row reports, predicts every key event in order and checks the event stream
// depends on kmce_pkg, kmce_if (kmce_in_if, kmce_out_if) and the core rtl
module tb_top;
  import kmce_pkg::*;

  localparam int ROWS         = 4;
  localparam int KEYS         = 8;
  localparam int HALVES       = 2 * ROWS;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [STATE_W-1:0] state;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n;

  kmce_in_if  in_if ();
  kmce_out_if out_if ();

  key_matrix_change_events_core #(
    .ROW_COUNT         (ROWS),
    .KEYS_PER_HALF_ROW (KEYS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // predicted matrix image, indexed by hand * ROWS + row
  logic [SWITCH_W-1:0] held_bits  [HALVES];
  logic [SWITCH_W-1:0] prior_bits [HALVES];
  key_event_t          pending_events [$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int reports_sent;
  int events_seen;

  always #10 clk = ~clk;

  // state moves at the transfer, then one event per touched column from bit 0 upward
  function automatic void predict_report(input logic hand, input logic [ROW_W-1:0] row,
                                         input logic [SWITCH_W-1:0] bits, input logic fresh);
    int                  idx;
    int                  base;
    int                  total;
    int                  n;
    logic [SWITCH_W-1:0] kept;
    logic [SWITCH_W-1:0] now_bits;
    logic [SWITCH_W-1:0] was_bits;
    key_event_t          ev;
    if (row >= ROWS) return;
    idx = hand ? ROWS + int'(row) : int'(row);
    kept = (KEYS < SWITCH_W) ? (bits & SWITCH_W'((1 << KEYS) - 1)) : bits;
    prior_bits[idx] = held_bits[idx];
    if (fresh) held_bits[idx] = kept;
    now_bits = held_bits[idx];
    was_bits = prior_bits[idx];
    if (now_bits == '0 && was_bits == '0) return;
    base = hand ? 2 * KEYS - 1 : KEYS - 1;
    total = 0;
    for (int i = 0; i < HALVES; i++) total += $countones(held_bits[i]);
    if (total > int'(TOTAL_MAX)) total = int'(TOTAL_MAX);
    n = 0;
    for (int b = 0; b < KEYS && b < SWITCH_W; b++) begin
      if (was_bits[b] || now_bits[b]) begin
        ev.row    = row;
        ev.column = COL_W'(base - b);
        ev.state  = {now_bits[b], was_bits[b]};
        ev.total  = TOTAL_W'(total);
        ev.last   = 1'b0;
        pending_events.push_back(ev);
        n++;
      end
    end
    if (n > 0) begin
      ev = pending_events.pop_back();
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
  endfunction

  // valid is left high after a transfer and while waiting for ready; the idle loop lowers it first
  task automatic send_report(input logic hand, input logic [ROW_W-1:0] row,
                             input logic [SWITCH_W-1:0] bits, input logic fresh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.hand_side   <= hand;
    in_if.scan_row    <= row;
    in_if.switch_bits <= bits;
    in_if.fresh_data  <= fresh;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_report(hand, row, bits, fresh);
    reports_sent++;
  endtask

  task automatic wait_drained(input bit with_tail);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    if (with_tail) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all-zero and stale-zero reports must stay silent
  task automatic test_quiet_rows();
    send_report(1'b0, 2'd0, 8'h00, 1'b1);
    send_report(1'b1, 2'd2, 8'h00, 1'b0);
  endtask

  // press, hold through a stale report whose bits are ignored, release, then quiet
  task automatic test_press_hold_release();
    send_report(1'b0, 2'd1, 8'hFF, 1'b1);
    send_report(1'b0, 2'd1, 8'h5A, 1'b0);
    send_report(1'b0, 2'd1, 8'h00, 1'b1);
    send_report(1'b0, 2'd1, 8'h00, 1'b1);
  endtask

  // right half columns 15 down to 8, mixed held and released keys
  task automatic test_right_hand_edges();
    send_report(1'b1, 2'd3, 8'h81, 1'b1);
    send_report(1'b1, 2'd3, 8'h01, 1'b1);
    send_report(1'b1, 2'd3, 8'h00, 1'b1);
  endtask

  // fill every half-row to reach the full count, then clear them all
  task automatic test_full_matrix();
    for (int i = 0; i < HALVES; i++)
      send_report(i >= ROWS, ROW_W'(i % ROWS), 8'hFF, 1'b1);
    for (int i = 0; i < HALVES; i++)
      send_report(i >= ROWS, ROW_W'(i % ROWS), 8'h00, 1'b1);
  endtask

  // mostly plausible scans that toggle a few switches, with some fully random noise
  task automatic test_random_scan(input int count);
    int                  idx;
    logic                hand;
    logic [ROW_W-1:0]    row;
    logic [SWITCH_W-1:0] bits;
    logic                fresh;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20) begin
        hand  = 1'($urandom_range(1));
        row   = ROW_W'($urandom_range(3));
        bits  = SWITCH_W'($urandom_range(255));
        fresh = 1'($urandom_range(1));
      end else begin
        idx   = int'($urandom_range(HALVES - 1));
        hand  = (idx >= ROWS);
        row   = ROW_W'(idx % ROWS);
        bits  = held_bits[idx];
        repeat ($urandom_range(3)) bits[$urandom_range(SWITCH_W - 1)] ^= 1'b1;
        fresh = ($urandom_range(9) != 0);
      end
      send_report(hand, row, bits, fresh);
    end
  endtask

  // event sink: random backpressure and in-order comparison
  initial begin
    key_event_t got;
    key_event_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.row    = out_if.event_row;
        got.column = out_if.event_column;
        got.state  = out_if.key_state;
        got.total  = out_if.keys_down_total;
        got.last   = out_if.last_event;
        events_seen++;
        if (pending_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected event: expected none", $time);
          $display("%0t:   actual row %0d col %0d state %0d total %0d last %0d",
                   $time, got.row, got.column, got.state, got.total, got.last);
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: event mismatch: expected row %0d col %0d state %0d total %0d",
                     $time, want.row, want.column, want.state, want.total);
            $display("%0t:   expected last %0d", $time, want.last);
            $display("%0t:   actual row %0d col %0d state %0d total %0d last %0d",
                     $time, got.row, got.column, got.state, got.total, got.last);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    errors        = 0;
    reports_sent  = 0;
    events_seen   = 0;
    send_idle_pct = 6;
    recv_idle_pct = 72;
    for (int i = 0; i < HALVES; i++) begin
      held_bits[i]  = '0;
      prior_bits[i] = '0;
    end
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.hand_side   <= 1'b0;
    in_if.scan_row    <= '0;
    in_if.switch_bits <= '0;
    in_if.fresh_data  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_quiet_rows();
    test_press_hold_release();
    test_right_hand_edges();
    test_full_matrix();
    test_random_scan(84);
    wait_drained(1'b0);

    send_idle_pct = 72;
    recv_idle_pct = 6;
    test_random_scan(83);
    wait_drained(1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_scan(83);
    wait_drained(1'b1);

    if (pending_events.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted events never arrived", $time, pending_events.size());
    end
    $display("covered %0d half-row reports and %0d key events from directed and random scans",
             reports_sent, events_seen);
    $display("under slow-sink, slow-source and back-to-back handshake mixes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* key_matrix_change_events_core.f */
hw/rtl/kmce_pkg.sv
hw/rtl/kmce_if.sv
hw/rtl/kmce_state.sv
hw/rtl/kmce_emit.sv
hw/rtl/key_matrix_change_events_core.sv
verif/tb_top.sv
